@@ design/rbc_pkg.sv @@
`default_nettype none
package rbc_pkg;

  localparam int ROB_DEPTH_DEF    = 64;
  localparam int COMMIT_WIDTH_DEF = 4;
  localparam int ADDR_BITS_DEF    = 16;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 80;

  localparam logic [2:0] ACT_DISPATCH  = 3'd0;
  localparam logic [2:0] ACT_WRITEBACK = 3'd1;
  localparam logic [2:0] ACT_COMMIT    = 3'd2;
  localparam logic [2:0] ACT_FLUSH     = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;

  localparam logic [1:0] KIND_NORMAL = 2'd0;
  localparam logic [1:0] KIND_JR     = 2'd1;
  localparam logic [1:0] KIND_BRANCH = 2'd2;
  localparam logic [1:0] KIND_STORE  = 2'd3;

  localparam logic [1:0] MK_NONE   = 2'd0;
  localparam logic [1:0] MK_JR     = 2'd1;
  localparam logic [1:0] MK_BRANCH = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load_in;       // capture accepted input
    logic single_emit;   // one-result actions: dispatch, writeback, flush, others
    logic rd_issue;      // start RAM read
    logic rd_head;       // read address is head (else input tag)
    logic read_emit;     // emit read-by-tag result
    logic scan_capture;  // retire entry whose data just came back
    logic drain_emit;    // emit one buffered commit result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] action;
    logic       out_free;
    logic       can_retire;
    logic       drain_last;
  } status_t;

endpackage
`default_nettype wire

@@ design/rbc_ram.sv @@
`default_nettype none
module rbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/rbc_ctrl.sv @@
`default_nettype none
module rbc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire rbc_pkg::status_t status,
  output rbc_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    IDLE, EXEC, READ_WAIT, READ_EMIT, SCAN, SCAN_WAIT, DRAIN
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = (state == IDLE);
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = EXEC;
        end
      end
      EXEC: begin
        if (status.action == rbc_pkg::ACT_READ) begin
          cmd.rd_issue = 1'b1;
          state_next   = READ_WAIT;
        end else if (status.action == rbc_pkg::ACT_COMMIT) begin
          state_next = SCAN;
        end else if (status.out_free) begin
          cmd.single_emit = 1'b1;
          state_next      = IDLE;
        end
      end
      READ_WAIT: state_next = READ_EMIT;
      READ_EMIT: begin
        if (status.out_free) begin
          cmd.read_emit = 1'b1;
          state_next    = IDLE;
        end
      end
      SCAN: begin
        if (status.can_retire) begin
          cmd.rd_issue = 1'b1;
          cmd.rd_head  = 1'b1;
          state_next   = SCAN_WAIT;
        end else begin
          state_next = DRAIN;
        end
      end
      SCAN_WAIT: begin
        cmd.scan_capture = 1'b1;
        state_next       = SCAN;
      end
      DRAIN: begin
        if (status.out_free) begin
          cmd.drain_emit = 1'b1;
          if (status.drain_last) begin
            state_next = IDLE;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ design/rbc_datapath.sv @@
`default_nettype none
module rbc_datapath #(
  parameter int ROB_DEPTH    = rbc_pkg::ROB_DEPTH_DEF,
  parameter int COMMIT_WIDTH = rbc_pkg::COMMIT_WIDTH_DEF,
  parameter int ADDR_BITS    = rbc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rbc_pkg::cmd_t                    cmd,
  output rbc_pkg::status_t                      status,
  input  wire logic [rbc_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic [rbc_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [rbc_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                  m_tlast
);

  localparam int PW   = $clog2(ROB_DEPTH);
  localparam int OW   = PW + 1;
  localparam int CNTW = $clog2(COMMIT_WIDTH + 1);
  localparam int BW   = (COMMIT_WIDTH > 1) ? $clog2(COMMIT_WIDTH) : 1;
  localparam logic [15:0] DEST_MASK =
    (ADDR_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << ADDR_BITS) - 64'd1);

  // captured input
  logic [2:0]  act;
  logic [1:0]  itype;
  logic [15:0] dst;
  logic [5:0]  tg;
  logic [31:0] val;

  // control state
  logic [ROB_DEPTH-1:0] busy, ready, res_valid;
  logic [PW-1:0]        head, tail;
  logic [OW-1:0]        occ;
  logic [CNTW-1:0]      cnt, didx;
  logic                 stop;

  // commit buffer
  logic [5:0]  buf_tag  [COMMIT_WIDTH];
  logic [31:0] buf_val  [COMMIT_WIDTH];
  logic [15:0] buf_dest [COMMIT_WIDTH];
  logic [1:0]  buf_kind [COMMIT_WIDTH];
  logic [1:0]  buf_mk   [COMMIT_WIDTH];

  logic [PW-1:0] tidx, rd_addr, head_nxt;
  logic          tag_in_range, disp_ok, wb_ok;
  logic [31:0]   res_rdata;
  logic [17:0]   meta_rdata;
  logic [1:0]    sc_kind, sc_mk;
  logic [OW-1:0] occ_single;

  // output fields
  logic [5:0]  o_tag;
  logic [31:0] o_value;
  logic [15:0] o_dest, o_redir;
  logic        o_retired, o_taken, o_acc, o_full, o_last;
  logic [1:0]  o_rtype, o_mk;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (32'(p) >= ROB_DEPTH - 1) ? PW'(1) : p + PW'(1);
  endfunction

  function automatic logic is_full(input logic [OW-1:0] o);
    return (32'(o) + 32'd4) >= ROB_DEPTH;
  endfunction

  assign tidx         = PW'(tg);
  assign tag_in_range = 32'(tg) < ROB_DEPTH;
  assign disp_ok      = !busy[tail];
  assign wb_ok        = (tg != 6'd0) && tag_in_range && busy[tidx] && !ready[tidx];
  assign rd_addr      = cmd.rd_head ? head : tidx;
  assign head_nxt     = ptr_inc(head);

  rbc_ram #(.WIDTH(32), .DEPTH(ROB_DEPTH)) u_res_ram (
    .clk   (clk),
    .we    (cmd.single_emit && act == rbc_pkg::ACT_WRITEBACK && wb_ok),
    .waddr (tidx),
    .wdata (val),
    .re    (cmd.rd_issue),
    .raddr (rd_addr),
    .rdata (res_rdata)
  );

  // {kind, dest}
  rbc_ram #(.WIDTH(18), .DEPTH(ROB_DEPTH)) u_meta_ram (
    .clk   (clk),
    .we    (cmd.single_emit && act == rbc_pkg::ACT_DISPATCH && disp_ok),
    .waddr (tail),
    .wdata ({itype, dst}),
    .re    (cmd.rd_issue),
    .raddr (head),
    .rdata (meta_rdata)
  );

  assign sc_kind = meta_rdata[17:16];
  always_comb begin
    priority if (sc_kind == rbc_pkg::KIND_JR) begin
      sc_mk = rbc_pkg::MK_JR;
    end else if (sc_kind == rbc_pkg::KIND_BRANCH && (res_rdata[31] != res_rdata[30])) begin
      sc_mk = rbc_pkg::MK_BRANCH;
    end else begin
      sc_mk = rbc_pkg::MK_NONE;
    end
  end

  always_comb begin
    status.action     = act;
    status.out_free   = !m_tvalid || m_tready;
    status.can_retire = (32'(cnt) < COMMIT_WIDTH) && !stop && busy[head] && ready[head];
    status.drain_last = (cnt == '0) || (didx + CNTW'(1) == cnt);
  end

  // result fields of every emitted result: one-result actions, read and commit drain
  always_comb begin
    o_tag      = '0;
    o_value    = '0;
    o_dest     = '0;
    o_redir    = '0;
    o_retired  = 1'b0;
    o_taken    = 1'b0;
    o_acc      = 1'b0;
    o_rtype    = '0;
    o_mk       = rbc_pkg::MK_NONE;
    o_last     = 1'b1;
    occ_single = occ;
    if (cmd.single_emit) begin
      unique case (act)
        rbc_pkg::ACT_DISPATCH: begin
          o_tag = 6'(tail);
          o_acc = disp_ok;
          if (disp_ok) begin
            occ_single = occ + OW'(1);
          end
        end
        rbc_pkg::ACT_WRITEBACK: begin
          o_tag = tg;
          o_acc = wb_ok;
        end
        rbc_pkg::ACT_FLUSH: occ_single = '0;
        default: ;
      endcase
    end else if (cmd.read_emit) begin
      o_tag   = tg;
      o_value = (tag_in_range && res_valid[tidx]) ? res_rdata : 32'd0;
    end else if (cmd.drain_emit && cnt != '0) begin
      o_tag     = buf_tag[didx[BW-1:0]];
      o_value   = buf_val[didx[BW-1:0]];
      o_dest    = buf_dest[didx[BW-1:0]];
      o_retired = 1'b1;
      o_rtype   = buf_kind[didx[BW-1:0]];
      o_taken   = o_value[31];
      o_mk      = buf_mk[didx[BW-1:0]];
      o_redir   = (o_mk != rbc_pkg::MK_NONE) ? (o_value[15:0] & DEST_MASK) : 16'd0;
      o_last    = status.drain_last;
    end
    o_full = is_full(occ_single);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act   <= s_tuser;
      itype <= s_tdata[1:0];
      dst   <= s_tdata[17:2];
      tg    <= s_tdata[23:18];
      val   <= s_tdata[55:24];
    end
    if (cmd.scan_capture) begin
      buf_tag[cnt[BW-1:0]]  <= 6'(head);
      buf_val[cnt[BW-1:0]]  <= res_rdata;
      buf_dest[cnt[BW-1:0]] <= meta_rdata[15:0] & DEST_MASK;
      buf_kind[cnt[BW-1:0]] <= sc_kind;
      buf_mk[cnt[BW-1:0]]   <= sc_mk;
    end
    if (cmd.single_emit || cmd.read_emit || cmd.drain_emit) begin
      m_tdata <= {2'b00, o_full, o_acc, o_redir, o_mk, o_taken, o_rtype, o_retired,
                  o_dest, o_value, o_tag};
      m_tlast <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= '0;
      ready     <= '0;
      res_valid <= '0;
      head      <= PW'(1);
      tail      <= PW'(1);
      occ       <= '0;
      cnt       <= '0;
      didx      <= '0;
      stop      <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.single_emit || cmd.read_emit || cmd.drain_emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load_in) begin
        cnt  <= '0;
        didx <= '0;
        stop <= 1'b0;
      end
      if (cmd.single_emit) begin
        unique case (act)
          rbc_pkg::ACT_DISPATCH: begin
            if (disp_ok) begin
              busy[tail]  <= 1'b1;
              ready[tail] <= 1'b0;
              tail        <= ptr_inc(tail);
              occ         <= occ + OW'(1);
            end
          end
          rbc_pkg::ACT_WRITEBACK: begin
            if (wb_ok) begin
              ready[tidx]     <= 1'b1;
              res_valid[tidx] <= 1'b1;
            end
          end
          rbc_pkg::ACT_FLUSH: begin
            busy      <= '0;
            ready     <= '0;
            res_valid <= '0;
            head      <= PW'(1);
            tail      <= PW'(1);
            occ       <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.scan_capture) begin
        busy[head]  <= 1'b0;
        ready[head] <= 1'b0;
        head        <= head_nxt;
        if (occ != '0) begin
          occ <= occ - OW'(1);
        end
        cnt  <= cnt + CNTW'(1);
        stop <= (sc_mk != rbc_pkg::MK_NONE);
      end
      if (cmd.drain_emit) begin
        didx <= didx + CNTW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= ROB_DEPTH - 1) else $error("occupancy above usable entries");
  a_entry0_free: assert property (@(posedge clk) disable iff (rst)
    !busy[0]) else $error("entry 0 allocated");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> (head == tail)) else $error("empty buffer with head != tail");
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (ready & ~busy) == '0) else $error("ready entry not busy");
`endif

endmodule
`default_nettype wire

@@ design/reorder_buffer_commit.sv @@
`default_nettype none
// Reorder buffer with in-order commit. Entries 1..ROB_DEPTH-1 form a circular
// buffer (entry 0 is never allocated). s_tuser selects the action: dispatch
// allocates the tail and returns its tag, writeback marks a busy entry ready
// with its value, read returns a tag's value for forwarding, flush empties the
// buffer, and a commit tick retires up to COMMIT_WIDTH ready entries from the
// head, stopping after a jump-register or a mispredicted branch (value bit 31
// taken vs bit 30 predicted) with the redirect address. Each transfer in gives
// one result, or one per retired entry on a commit tick (one if none retire),
// the final one with m_tlast. One item is in flight at a time (s_tready only
// when idle); a commit tick needs one read of the entry RAMs (one read port
// each) per retired entry before it emits its results. Every result also
// waits while m_tready holds back the one before it. No clearing pass: flush
// and reset clear the valid bits and pointers directly.
module reorder_buffer_commit #(
  parameter int ROB_DEPTH    = rbc_pkg::ROB_DEPTH_DEF,
  parameter int COMMIT_WIDTH = rbc_pkg::COMMIT_WIDTH_DEF,
  parameter int ADDR_BITS    = rbc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // inst_type[1:0], dest[17:2], tag[23:18], value[55:24]
  input  wire logic [rbc_pkg::IN_DATA_W-1:0]  s_tdata,
  // action[2:0]
  input  wire logic [rbc_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // out_tag[5:0], out_value[37:6], out_dest[53:38], retired[54],
  // retired_type[56:55], actual_taken[57], mispredict_kind[59:58],
  // redirect_addr[75:60], accepted[76], near_full[77], zero[79:78]
  output logic      [rbc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                                m_tlast
);

  rbc_pkg::cmd_t    cmd;
  rbc_pkg::status_t status;

  rbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rbc_datapath #(
    .ROB_DEPTH    (ROB_DEPTH),
    .COMMIT_WIDTH (COMMIT_WIDTH),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
